FILE: rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Register indexes, reset values, status and operation codes, item types.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Default width of the elapsed tick counter.
    localparam int COUNT_WIDTH = 20;

    // Field widths fixed by the register map and the result item.
    localparam int TIMEOUT_W  = 20;
    localparam int SCALE_W    = 16;
    localparam int TRIG_W     = 8;
    localparam int DIST_W     = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIG_W  = 2'd2;

    // Register reset values.
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd1000000;
    localparam logic [SCALE_W-1:0]   SCALE_RST   = 16'd1114;
    localparam logic [TRIG_W-1:0]    TRIG_W_RST  = 8'd10;

    // Operation codes of an input item.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Measurement status codes.
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_NO_ECHO  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_VALID    = 2'd3
    } status_t;

    // Measurement phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_HIGH = 3'b100
    } phase_t;

    // Input item as held in the input register.
    typedef struct packed {
        logic operation;
        logic echo_level;
    } cmd_t;

    // Current register settings.
    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [SCALE_W-1:0]   distance_scale;
        logic [TRIG_W-1:0]    trigger_width;
    } cfg_t;

    // Handshake between the input register and the ranging core.
    typedef struct packed {
        logic valid;
        cmd_t item;
    } stage_t;

endpackage

FILE: rtl/uer_if.sv
// ----------------------------------------------------------------------------
// uer_if: item channels of the ultrasonic echo ranger
// Command channel (tick or start) and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------

// Command channel: one tick with its echo sample, or a start request.
interface uer_cmd_if;
    logic valid;
    logic ready;
    logic operation;
    logic echo_level;

    modport source (output valid, output operation, output echo_level, input ready);
    modport sink   (input valid, input operation, input echo_level, output ready);
endinterface

// Result channel: one result item per command item.
interface uer_res_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] distance;

    modport source (output valid, output trigger_level, output busy_res,
                    output done_res, output status, output distance, input ready);
    modport sink   (input valid, input trigger_level, input busy_res,
                    input done_res, input status, input distance, output ready);
endinterface

FILE: rtl/uer_cfg_regs.sv
// ----------------------------------------------------------------------------
// uer_cfg_regs: configuration registers
// Holds timeout, distance scale and trigger width, written by index.
// ----------------------------------------------------------------------------
module uer_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data,
    output uer_pkg::cfg_t                      cfg
);

    uer_pkg::cfg_t cfg_reg;
    uer_pkg::cfg_t cfg_next;

    // Decode the write; an index outside the map changes nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                uer_pkg::REG_TIMEOUT:
                    cfg_next.timeout_ticks = cfg_data[uer_pkg::TIMEOUT_W-1:0];
                uer_pkg::REG_SCALE:
                    cfg_next.distance_scale = cfg_data[uer_pkg::SCALE_W-1:0];
                uer_pkg::REG_TRIG_W:
                    cfg_next.trigger_width = cfg_data[uer_pkg::TRIG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks  <= uer_pkg::TIMEOUT_RST;
            cfg_reg.distance_scale <= uer_pkg::SCALE_RST;
            cfg_reg.trigger_width  <= uer_pkg::TRIG_W_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/uer_in_stage.sv
// ----------------------------------------------------------------------------
// uer_in_stage: input register
// Captures one command item and hands it to the ranging core.
// ----------------------------------------------------------------------------
module uer_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    uer_cmd_if.sink         cmd,
    input  logic            core_ready,
    output uer_pkg::stage_t stage
);

    logic          valid_reg;
    logic          valid_next;
    uer_pkg::cmd_t item_reg;
    logic          load;

    // The register takes a new item when empty or when the core takes the held one.
    assign cmd.ready  = !valid_reg || core_ready;
    assign load       = cmd.valid && cmd.ready;
    assign valid_next = load || (valid_reg && !core_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.operation  <= cmd.operation;
            item_reg.echo_level <= cmd.echo_level;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

FILE: rtl/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core: ranging state machine and result register
// Updates phase, tick counter and trigger counter per item, scales the echo
// width into a distance and registers the result item.
// ----------------------------------------------------------------------------
module uer_core #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  uer_pkg::cfg_t   cfg,
    input  uer_pkg::stage_t stage,
    output logic            core_ready,
    uer_res_if.source       res
);

    // Compare width covers both the counter and the timeout register.
    localparam int CMP_W  = (COUNT_WIDTH > uer_pkg::TIMEOUT_W) ?
                            COUNT_WIDTH : uer_pkg::TIMEOUT_W;
    // Quotient width for the saturation compare, at least one bit above distance.
    localparam int QUO_W  = (COUNT_WIDTH > uer_pkg::DIST_W) ?
                            COUNT_WIDTH : uer_pkg::DIST_W + 1;
    localparam int PROD_W = COUNT_WIDTH + uer_pkg::SCALE_W;

    uer_pkg::phase_t               phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]        cnt_reg, cnt_next;
    logic [uer_pkg::TRIG_W-1:0]    trig_reg, trig_next;
    uer_pkg::status_t              status_reg, status_next;
    logic [uer_pkg::DIST_W-1:0]    dist_reg, dist_next;
    logic                          done;

    logic                          out_valid_reg;
    logic                          out_trig_reg;
    logic                          out_busy_reg;
    logic                          out_done_reg;
    uer_pkg::status_t              out_status_reg;
    logic [uer_pkg::DIST_W-1:0]    out_dist_reg;

    logic                          take;
    logic [COUNT_WIDTH-1:0]        cnt_inc;
    logic                          inc_timeout;
    logic                          one_timeout;
    logic [PROD_W-1:0]             product;
    logic [QUO_W-1:0]              quotient;
    logic [uer_pkg::DIST_W-1:0]    scaled;

    // The result register frees up when empty or when its item is taken.
    assign core_ready = !out_valid_reg || res.ready;
    assign take       = stage.valid && core_ready;

    // Saturating count step and timeout checks; the all-ones count is a timeout too.
    assign cnt_inc     = (cnt_reg == '1) ? cnt_reg : cnt_reg + COUNT_WIDTH'(1);
    assign inc_timeout = (CMP_W'(cnt_inc) >= CMP_W'(cfg.timeout_ticks)) ||
                         (cnt_inc == '1);
    assign one_timeout = (CMP_W'(1) >= CMP_W'(cfg.timeout_ticks)) ||
                         (COUNT_WIDTH'(1) == '1);

    // Width times Q0.16 scale, truncated, saturated to the distance range.
    assign product  = PROD_W'(cnt_reg) * PROD_W'(cfg.distance_scale);
    assign quotient = QUO_W'(product[PROD_W-1:uer_pkg::SCALE_W]);
    assign scaled   = (quotient > QUO_W'({uer_pkg::DIST_W{1'b1}})) ?
                      {uer_pkg::DIST_W{1'b1}} : quotient[uer_pkg::DIST_W-1:0];

    // Next state for one item.
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        trig_next   = trig_reg;
        status_next = status_reg;
        dist_next   = dist_reg;
        done        = 1'b0;

        if (stage.item.operation == uer_pkg::OP_START)
        begin
            // A start while a measurement runs is ignored.
            if (phase_reg != uer_pkg::PH_WAIT && phase_reg != uer_pkg::PH_HIGH)
            begin
                phase_next = uer_pkg::PH_WAIT;
                cnt_next   = '0;
                trig_next  = cfg.trigger_width;
            end
        end
        else
        begin
            if (trig_reg != '0)
            begin
                trig_next = trig_reg - uer_pkg::TRIG_W'(1);
            end

            unique case (phase_reg)
                uer_pkg::PH_WAIT:
                begin
                    if (stage.item.echo_level)
                    begin
                        // Echo rose: its first high sample counts as one tick.
                        phase_next = uer_pkg::PH_HIGH;
                        cnt_next   = COUNT_WIDTH'(1);
                        if (one_timeout)
                        begin
                            phase_next  = uer_pkg::PH_IDLE;
                            status_next = uer_pkg::ST_TOO_LONG;
                            dist_next   = '0;
                            done        = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                        if (inc_timeout)
                        begin
                            phase_next  = uer_pkg::PH_IDLE;
                            status_next = uer_pkg::ST_NO_ECHO;
                            dist_next   = '0;
                            done        = 1'b1;
                        end
                    end
                end
                uer_pkg::PH_HIGH:
                begin
                    if (stage.item.echo_level)
                    begin
                        cnt_next = cnt_inc;
                        if (inc_timeout)
                        begin
                            phase_next  = uer_pkg::PH_IDLE;
                            status_next = uer_pkg::ST_TOO_LONG;
                            dist_next   = '0;
                            done        = 1'b1;
                        end
                    end
                    else
                    begin
                        // Echo fell: the pulse width is complete.
                        phase_next  = uer_pkg::PH_IDLE;
                        status_next = uer_pkg::ST_VALID;
                        dist_next   = scaled;
                        done        = 1'b1;
                    end
                end
                default:
                begin
                    // Idle, or an unused code treated as idle.
                    phase_next = uer_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Measurement state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= uer_pkg::PH_IDLE;
            cnt_reg    <= '0;
            trig_reg   <= '0;
            status_reg <= uer_pkg::ST_NONE;
            dist_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            trig_reg   <= trig_next;
            status_reg <= status_next;
            dist_reg   <= dist_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_ready)
        begin
            out_valid_reg <= stage.valid;
        end
    end

    // Result payload shows the state after the item.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_trig_reg   <= (trig_next != '0);
            out_busy_reg   <= (phase_next != uer_pkg::PH_IDLE);
            out_done_reg   <= done;
            out_status_reg <= status_next;
            out_dist_reg   <= dist_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.trigger_level = out_trig_reg;
    assign res.busy_res      = out_busy_reg;
    assign res.done_res      = out_done_reg;
    assign res.status        = out_status_reg;
    assign res.distance      = out_dist_reg;

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// A command item passes through the input register and then the result register;
// a stall on the result channel holds the result item and backs up the input.
// Throughput: one item per cycle while the result channel is not stalled; the
// state update and distance scaling take a single pass through the ranging core.
// Reset (rst_n, asynchronous, active low) clears the channels, puts the ranger
// in idle with status none yet and loads the register defaults.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: trigger and echo pulse timer
// Drives the trigger level and measures echo width into a distance.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
    uer_cmd_if.sink                        cmd,
    uer_res_if.source                      res
);

    uer_pkg::cfg_t   cfg;
    uer_pkg::stage_t stage;
    logic            core_ready;

    uer_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .core_ready (core_ready),
        .stage      (stage)
    );

    uer_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .stage      (stage),
        .core_ready (core_ready),
        .res        (res)
    );

`ifndef ASSERT_OFF
    // A finishing item always leaves the ranger idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.done_res |-> !res.busy_res)
        else $error("done result while still busy");

    // A nonzero distance only comes with a valid measurement.
    a_dist_status: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.distance != '0 |-> res.status == uer_pkg::ST_VALID)
        else $error("distance set without valid status");

    // Commands are held back only when both stages are full and the output stalls.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> res.valid && !res.ready && stage.valid)
        else $error("command stalled without output backpressure");
`endif

endmodule

FILE: tb/ultrasonic_echo_ranger_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_test: self-checking bench for the echo ranger
// Feeds tick and start items through the command channel while the receiver
// stalls at random. Each accepted item is run through a cycle-free predictor
// of the trigger, echo timing and distance scaling. Every result item is then
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_test;

    localparam int    CLK_PERIOD = 8;
    localparam int    RESET_CYCLES = 12;
    localparam int    LONG_HOLD = 400;
    localparam int    PRINT_CAP = 100;
    localparam int    PHASE_ITEMS = 80;
    localparam int    LONG_PULSE = 60;
    localparam time   RUN_LIMIT = 6_400_000;
    localparam logic [uer_pkg::TIMEOUT_W-1:0] TIMEOUT_MAX = '1;

    // Expected contents of one result item.
    typedef struct packed {
        logic                       trigger_level;
        logic                       busy_res;
        logic                       done_res;
        uer_pkg::status_t           status;
        logic [uer_pkg::DIST_W-1:0] distance;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                           cfg_wr_en;
    logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_data;

    uer_cmd_if cmd_ch ();
    uer_res_if res_ch ();

    ultrasonic_echo_ranger uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Items waiting to be offered, and readings waiting to come back.
    uer_pkg::cmd_t pending_cmds[$];
    reading_t      expected_readings[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned queued_total;
    int unsigned mismatch_count;
    int unsigned hold_left;
    logic        long_hold_req;

    // Predictor copy of the register settings.
    logic [uer_pkg::TIMEOUT_W-1:0] cfg_timeout;
    logic [uer_pkg::SCALE_W-1:0]   cfg_scale;
    logic [uer_pkg::TRIG_W-1:0]    cfg_trig_width;

    // Predictor copy of the ranging state.
    uer_pkg::phase_t                 pred_phase;
    logic [uer_pkg::COUNT_WIDTH-1:0] pred_elapsed;
    logic [uer_pkg::TRIG_W-1:0]      pred_trig_left;
    uer_pkg::status_t                pred_status;
    logic [uer_pkg::DIST_W-1:0]      pred_distance;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A measurement has run out once the counter meets the timeout or pins.
    function automatic logic limit_reached();
        return (pred_elapsed >= cfg_timeout) || (pred_elapsed == '1);
    endfunction

    function automatic void end_measurement(uer_pkg::status_t st,
                                            logic [uer_pkg::DIST_W-1:0] dist_val);
        pred_status   = st;
        pred_distance = dist_val;
        pred_phase    = uer_pkg::PH_IDLE;
    endfunction

    // Advance the ranging state by one item and return the reading it shows.
    function automatic reading_t predict_reading(logic op, logic echo);
        reading_t   rd;
        logic       done;
        logic [47:0] product;
        done = 1'b0;
        if (op == uer_pkg::OP_START)
        begin
            // A start while a measurement runs is ignored.
            if (pred_phase == uer_pkg::PH_IDLE)
            begin
                pred_phase     = uer_pkg::PH_WAIT;
                pred_elapsed   = '0;
                pred_trig_left = cfg_trig_width;
            end
        end
        else
        begin
            if (pred_trig_left != 0)
                pred_trig_left = pred_trig_left - uer_pkg::TRIG_W'(1);
            if (pred_phase == uer_pkg::PH_WAIT)
            begin
                if (echo)
                begin
                    // The echo rose: width counting starts at one.
                    pred_phase   = uer_pkg::PH_HIGH;
                    pred_elapsed = uer_pkg::COUNT_WIDTH'(1);
                    if (limit_reached())
                    begin
                        end_measurement(uer_pkg::ST_TOO_LONG, '0);
                        done = 1'b1;
                    end
                end
                else
                begin
                    if (pred_elapsed != '1)
                        pred_elapsed = pred_elapsed + uer_pkg::COUNT_WIDTH'(1);
                    if (limit_reached())
                    begin
                        end_measurement(uer_pkg::ST_NO_ECHO, '0);
                        done = 1'b1;
                    end
                end
            end
            else if (pred_phase == uer_pkg::PH_HIGH)
            begin
                if (echo)
                begin
                    if (pred_elapsed != '1)
                        pred_elapsed = pred_elapsed + uer_pkg::COUNT_WIDTH'(1);
                    if (limit_reached())
                    begin
                        end_measurement(uer_pkg::ST_TOO_LONG, '0);
                        done = 1'b1;
                    end
                end
                else
                begin
                    // Pulse over: scale the width in Q0.16 and saturate.
                    product = 48'(pred_elapsed) * 48'(cfg_scale);
                    if (product[47:16] > 32'd65535)
                        end_measurement(uer_pkg::ST_VALID, '1);
                    else
                        end_measurement(uer_pkg::ST_VALID, product[31:16]);
                    done = 1'b1;
                end
            end
        end
        rd.trigger_level = (pred_trig_left != 0);
        rd.busy_res      = (pred_phase != uer_pkg::PH_IDLE);
        rd.done_res      = done;
        rd.status        = pred_status;
        rd.distance      = pred_distance;
        return rd;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Driver: predicts each accepted item and offers the next one.
    always @(posedge clk)
    begin : cmd_driver
        logic offer;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_readings.push_back(
                    predict_reading(cmd_ch.operation, cmd_ch.echo_level));
                void'(pending_cmds.pop_front());
            end
            // An item that was offered but not taken stays on the channel.
            if (cmd_ch.valid && !cmd_ch.ready)
                offer = 1'b1;
            else
                offer = (pending_cmds.size() != 0)
                        && ($urandom_range(99) >= send_idle_pct);
            if (offer)
            begin
                cmd_ch.operation  <= pending_cmds[0].operation;
                cmd_ch.echo_level <= pending_cmds[0].echo_level;
            end
            cmd_ch.valid <= offer;
        end
    end

    // Receiver readiness, including the long hold-off that backs up the block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                hold_left    <= LONG_HOLD;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: checks every accepted result item against the oldest reading.
    always @(posedge clk)
    begin : res_monitor
        reading_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("result item with no expected reading");
            else
            begin
                want = expected_readings.pop_front();
                if (res_ch.trigger_level !== want.trigger_level)
                    report_mismatch($sformatf("trigger_level %b, expected %b",
                                    res_ch.trigger_level, want.trigger_level));
                if (res_ch.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %b, expected %b",
                                    res_ch.busy_res, want.busy_res));
                if (res_ch.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res %b, expected %b",
                                    res_ch.done_res, want.done_res));
                if (res_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                    res_ch.status, want.status));
                if (res_ch.distance !== want.distance)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                    res_ch.distance, want.distance));
            end
        end
    end

    // Register write; the predictor takes the new value at the same time.
    task automatic set_register(logic [uer_pkg::CFG_ADDR_W-1:0] addr,
                                logic [uer_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        case (addr)
            uer_pkg::REG_TIMEOUT: cfg_timeout    = value[uer_pkg::TIMEOUT_W-1:0];
            uer_pkg::REG_SCALE:   cfg_scale      = value[uer_pkg::SCALE_W-1:0];
            uer_pkg::REG_TRIG_W:  cfg_trig_width = value[uer_pkg::TRIG_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(logic [uer_pkg::TIMEOUT_W-1:0] timeout,
                             logic [uer_pkg::SCALE_W-1:0] scale,
                             logic [uer_pkg::TRIG_W-1:0] trig);
        set_register(uer_pkg::REG_TIMEOUT, uer_pkg::CFG_DATA_W'(timeout));
        set_register(uer_pkg::REG_SCALE, uer_pkg::CFG_DATA_W'(scale));
        set_register(uer_pkg::REG_TRIG_W, uer_pkg::CFG_DATA_W'(trig));
        @(negedge clk);
    endtask

    task automatic queue_cmd(logic op, logic echo);
        uer_pkg::cmd_t c;
        c.operation  = op;
        c.echo_level = echo;
        pending_cmds.push_back(c);
        queued_total++;
    endtask

    task automatic queue_ticks(int unsigned count, logic echo);
        repeat (count) queue_cmd(uer_pkg::OP_TICK, echo);
    endtask

    // Wait until every item is in and every reading is back, then let the
    // pipeline settle before touching the registers.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || expected_readings.size() != 0
               || cmd_ch.valid);
        repeat (4) @(negedge clk);
    endtask

    // One measurement with random content, now and then noise or a stray start.
    task automatic queue_measurement();
        int unsigned lim;
        int unsigned pick;
        int unsigned low_n;
        int unsigned high_n;
        lim  = (cfg_timeout > 40) ? 40 : cfg_timeout;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            repeat ($urandom_range(5, 1))
                queue_cmd(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else
        begin
            queue_cmd(uer_pkg::OP_START, 1'($urandom_range(1)));
            // Some waits run past the timeout, the rest see an echo.
            low_n  = (pick < 24) ? lim + $urandom_range(2) : $urandom_range(lim);
            high_n = (pick < 38) ? lim + $urandom_range(3, 1) : $urandom_range(lim) + 1;
            queue_ticks(low_n, 1'b0);
            if (pick % 9 == 0)
                queue_cmd(uer_pkg::OP_START, 1'($urandom_range(1)));
            queue_ticks(high_n, 1'b1);
            queue_ticks($urandom_range(3, 1), 1'b0);
        end
    endtask

    task automatic random_phase(int unsigned send_pct, int unsigned recv_pct,
                                logic [uer_pkg::TIMEOUT_W-1:0] timeout,
                                logic [uer_pkg::SCALE_W-1:0] scale,
                                logic [uer_pkg::TRIG_W-1:0] trig, logic with_hold);
        int unsigned first;
        wait_drained();
        configure(timeout, scale, trig);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first = queued_total;
        while (queued_total - first < PHASE_ITEMS)
            queue_measurement();
        if (with_hold)
        begin
            long_hold_req = 1'b1;
            @(negedge clk);
            long_hold_req = 1'b0;
        end
    endtask

    // Stimulus sequence.
    initial
    begin : stimulus
        int unsigned mode;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_addr          = '0;
        cfg_data          = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = uer_pkg::OP_TICK;
        cmd_ch.echo_level = 1'b0;
        res_ch.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        queued_total      = 0;
        mismatch_count    = 0;
        hold_left         = 0;
        long_hold_req     = 1'b0;
        cfg_timeout       = uer_pkg::TIMEOUT_RST;
        cfg_scale         = uer_pkg::SCALE_RST;
        cfg_trig_width    = uer_pkg::TRIG_W_RST;
        pred_phase        = uer_pkg::PH_IDLE;
        pred_elapsed      = '0;
        pred_trig_left    = '0;
        pred_status       = uer_pkg::ST_NONE;
        pred_distance     = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: idle ticks, a start, a start while busy, a short pulse.
        queue_cmd(uer_pkg::OP_TICK, 1'b0);
        queue_cmd(uer_pkg::OP_TICK, 1'b1);
        queue_cmd(uer_pkg::OP_START, 1'b0);
        queue_cmd(uer_pkg::OP_START, 1'b1);
        queue_ticks(2, 1'b0);
        queue_ticks(3, 1'b1);
        queue_ticks(1, 1'b0);

        // Short timeout, full scale: no echo, echo too long, then a valid pulse.
        wait_drained();
        configure(uer_pkg::TIMEOUT_W'(3), '1, uer_pkg::TRIG_W'(1));
        queue_cmd(uer_pkg::OP_START, 1'b0);
        queue_ticks(3, 1'b0);
        queue_cmd(uer_pkg::OP_START, 1'b0);
        queue_ticks(3, 1'b1);
        queue_cmd(uer_pkg::OP_START, 1'b1);
        queue_ticks(1, 1'b0);
        queue_ticks(2, 1'b1);
        queue_ticks(1, 1'b0);

        // Longest timeout and full scale: a wide pulse gives a large distance.
        wait_drained();
        configure(TIMEOUT_MAX, '1, '1);
        queue_cmd(uer_pkg::OP_START, 1'b0);
        queue_ticks(LONG_PULSE, 1'b1);
        queue_ticks(2, 1'b0);

        // Random measurements under each idling mode, extreme and random settings.
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: random_phase(0, 0, uer_pkg::TIMEOUT_W'(1), '1, '1, 1'b1);
                1: random_phase(62, 0, '0, '0, '0, 1'b0);
                2: random_phase(0, 62, uer_pkg::TIMEOUT_W'(1), '0,
                                uer_pkg::TRIG_W'(1), 1'b0);
                default: random_phase(37, 37, '0, '1, '1, 1'b0);
            endcase
            random_phase(mode == 0 ? 0 : (mode == 2 ? 0 : (mode == 1 ? 62 : 37)),
                         mode == 0 ? 0 : (mode == 1 ? 0 : (mode == 2 ? 62 : 37)),
                         uer_pkg::TIMEOUT_W'($urandom_range(40, 2)),
                         uer_pkg::SCALE_W'($urandom_range(65535)),
                         uer_pkg::TRIG_W'($urandom_range(255)), 1'b0);
        end

        // Let the last results come through, then give the verdict.
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule
